/* hdl/bbsf_pkg.sv */
package bbsf_pkg;

    // Field widths fixed by the interface.
    localparam int COUNT_W     = 28;
    localparam int PRES_W      = 24;
    localparam int RR_W        = 16;
    localparam int SECS_W      = 24;
    localparam int SAMPLE_W    = 16;
    localparam int SLOT_W      = 9;
    localparam int RR_SLOT_W   = 5;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 24;
    localparam int DIVISOR_W   = 8;
    localparam int SUM_W       = 36;
    localparam int RECORDS_W   = 32;

    // Serial divider geometry.
    localparam int DIVIDEND_W  = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

    // Framing.
    localparam int TICKS_PER_RECORD = 500;
    localparam int RR_PER_RECORD    = 25;
    localparam int RR_EVERY         = 20;
    localparam int RR_SUB_W         = $clog2(RR_EVERY);
    localparam int FLUSH_EVERY      = 10;
    localparam int FLUSH_W          = $clog2(FLUSH_EVERY);

    localparam int SAT_LIMIT   = 32767;
    localparam int FLOW_SHIFT  = 17;
    localparam int FLOW_MUL_SH = 15;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_DELAY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_AVG   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THORACIC_DIV   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ABDOMEN_DIV    = 8'd3;

    localparam logic [SECS_W-1:0]    RST_BASELINE_DELAY = 24'd1200;
    localparam logic [DIVISOR_W-1:0] RST_BASELINE_AVG   = 8'd50;
    localparam logic [DIVISOR_W-1:0] RST_THORACIC_DIV   = 8'd15;
    localparam logic [DIVISOR_W-1:0] RST_ABDOMEN_DIV    = 8'd11;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot_index;
        logic                 rr_take;
        logic [RR_SLOT_W-1:0] rr_slot;
        logic                 record_end;
        logic                 header_flush_due;
    } t_frame;

endpackage

/* hdl/belt_baseline_scaler_framer_top.sv */
// Belt baseline scaler and framer. Each accepted tick yields exactly one
// result. One serial divider, one quotient bit per cycle over 36 bits, does
// every division: the two baseline averages on the tick that completes the
// baseline, then both belt samples on every tick. The input is not ready while
// a tick is in work, but a finished result waits in its own output register,
// so the next tick may enter meanwhile.
// Configuration writes are always taken and should only be made while the
// block is idle.
module belt_baseline_scaler_framer_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [bbsf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bbsf_pkg::CFG_DATA_W-1:0]        i_cfg_data,

    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [bbsf_pkg::COUNT_W-1:0]           i_thoracic_count,
    input  logic [bbsf_pkg::COUNT_W-1:0]           i_abdomen_count,
    input  logic signed [bbsf_pkg::PRES_W-1:0]     i_pressure_q16,
    input  logic [bbsf_pkg::RR_W-1:0]              i_rr_interval_ms,
    input  logic [bbsf_pkg::SECS_W-1:0]            i_elapsed_seconds,

    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [bbsf_pkg::SAMPLE_W-1:0]   o_thoracic_sample,
    output logic signed [bbsf_pkg::SAMPLE_W-1:0]   o_abdomen_sample,
    output logic signed [bbsf_pkg::SAMPLE_W-1:0]   o_flow_sample,
    output logic [bbsf_pkg::SLOT_W-1:0]            o_slot_index,
    output logic                                   o_rr_take,
    output logic [bbsf_pkg::RR_SLOT_W-1:0]         o_rr_slot,
    output logic [bbsf_pkg::RR_W-1:0]              o_rr_value,
    output logic                                   o_record_end,
    output logic                                   o_header_flush_due,
    output logic                                   o_baseline_ready
);

    localparam int PROD_W = bbsf_pkg::PRES_W + bbsf_pkg::SAMPLE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ACC,
        S_BT_GO, S_BT_WT, S_BA_GO, S_BA_WT,
        S_ST_GO, S_ST_WT, S_SA_GO, S_SA_WT,
        S_FLOW1, S_FLOW2, S_FIN
    } t_state;

    t_state r_state;

    // Configuration.
    logic [bbsf_pkg::SECS_W-1:0]    r_cfg_delay;
    logic [bbsf_pkg::DIVISOR_W-1:0] r_cfg_avg;
    logic [bbsf_pkg::DIVISOR_W-1:0] r_cfg_tdiv;
    logic [bbsf_pkg::DIVISOR_W-1:0] r_cfg_adiv;

    // Baseline state.
    logic                           r_bvalid;
    logic [bbsf_pkg::COUNT_W-1:0]   r_base_t;
    logic [bbsf_pkg::COUNT_W-1:0]   r_base_a;
    logic [bbsf_pkg::SUM_W-1:0]     r_sum_t;
    logic [bbsf_pkg::SUM_W-1:0]     r_sum_a;
    logic [bbsf_pkg::DIVISOR_W-1:0] r_avg;

    // Tick in work.
    logic [bbsf_pkg::COUNT_W-1:0]         r_in_thor;
    logic [bbsf_pkg::COUNT_W-1:0]         r_in_abd;
    logic signed [bbsf_pkg::PRES_W-1:0]   r_in_pres;
    logic [bbsf_pkg::SECS_W-1:0]          r_in_secs;
    logic [bbsf_pkg::RR_W-1:0]            r_in_rr;
    bbsf_pkg::t_frame                     r_frame;
    logic                                 r_neg;
    logic signed [bbsf_pkg::SAMPLE_W-1:0] r_samp_t;
    logic signed [bbsf_pkg::SAMPLE_W-1:0] r_samp_a;
    logic signed [PROD_W-1:0]             r_prod;
    logic signed [bbsf_pkg::SAMPLE_W-1:0] r_flow;

    // Output register.
    logic                                 r_o_valid;
    logic signed [bbsf_pkg::SAMPLE_W-1:0] r_o_thor;
    logic signed [bbsf_pkg::SAMPLE_W-1:0] r_o_abd;
    logic signed [bbsf_pkg::SAMPLE_W-1:0] r_o_flow;
    bbsf_pkg::t_frame                     r_o_frame;
    logic [bbsf_pkg::RR_W-1:0]            r_o_rr;
    logic                                 r_o_bready;

    bbsf_pkg::t_frame                     frame;
    logic                                 accept;
    logic                                 div_start;
    logic                                 div_done;
    logic [bbsf_pkg::DIVIDEND_W-1:0]      div_dividend;
    logic [bbsf_pkg::DIVISOR_W-1:0]       div_divisor;
    logic [bbsf_pkg::DIVIDEND_W-1:0]      div_quot;

    logic [bbsf_pkg::COUNT_W-1:0]         sel_cnt;
    logic [bbsf_pkg::COUNT_W-1:0]         sel_base;
    logic [bbsf_pkg::DIVISOR_W-1:0]       sel_div;
    logic [bbsf_pkg::COUNT_W:0]           diff;
    logic [bbsf_pkg::COUNT_W:0]           mag;
    logic                                 diff_neg;
    logic [bbsf_pkg::SAMPLE_W-2:0]        q_sat;
    logic signed [bbsf_pkg::SAMPLE_W-1:0] samp;

    logic                                 take_avg;
    logic [bbsf_pkg::DIVISOR_W:0]         avg_inc;
    logic signed [PROD_W-1:0]             pres_ext;
    logic signed [PROD_W-1:0]             prod;
    logic signed [PROD_W-1:0]             biased;
    logic signed [PROD_W-1:0]             flow_q;
    logic signed [bbsf_pkg::SAMPLE_W-1:0] flow_sat;

    assign accept      = i_valid && (r_state == S_IDLE);
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    bbsf_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .o_frame (frame)
    );

    bbsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Operand selection for the shared divider.
    always_comb begin
        sel_cnt  = (r_state == S_SA_GO) ? r_in_abd : r_in_thor;
        sel_base = (r_state == S_SA_GO) ? r_base_a : r_base_t;
        sel_div  = (r_state == S_SA_GO) ? r_cfg_adiv : r_cfg_tdiv;
        diff     = {1'b0, sel_cnt} - {1'b0, sel_base};
        diff_neg = diff[bbsf_pkg::COUNT_W];
        mag      = diff_neg ? (~diff + 1'b1) : diff;

        div_start    = 1'b0;
        div_dividend = r_sum_t;
        div_divisor  = r_avg;
        case (r_state)
            S_BT_GO: begin
                div_start = 1'b1;
            end
            S_BA_GO: begin
                div_start    = 1'b1;
                div_dividend = r_sum_a;
            end
            S_ST_GO, S_SA_GO: begin
                div_start    = 1'b1;
                div_dividend = bbsf_pkg::DIVIDEND_W'(mag);
                div_divisor  = (sel_div == '0) ? bbsf_pkg::DIVISOR_W'(1) : sel_div;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Saturate the quotient magnitude and restore the sign.
    always_comb begin
        if (div_quot > bbsf_pkg::DIVIDEND_W'(bbsf_pkg::SAT_LIMIT)) begin
            q_sat = (bbsf_pkg::SAMPLE_W - 1)'(bbsf_pkg::SAT_LIMIT);
        end else begin
            q_sat = div_quot[bbsf_pkg::SAMPLE_W-2:0];
        end
        samp = r_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    end

    always_comb begin
        take_avg = !r_bvalid && (r_in_thor != '0) && (r_in_secs >= r_cfg_delay);
        avg_inc  = {1'b0, r_avg} + 1'b1;

        // pressure * 32767 as a shift and a subtraction.
        pres_ext = PROD_W'(r_in_pres);
        prod     = (pres_ext <<< bbsf_pkg::FLOW_MUL_SH) - pres_ext;

        // Arithmetic shift rounds toward minus infinity, so negative values
        // are biased first to truncate toward zero.
        biased = r_prod + (r_prod[PROD_W-1] ?
                 PROD_W'((1 << bbsf_pkg::FLOW_SHIFT) - 1) : PROD_W'(0));
        flow_q = biased >>> bbsf_pkg::FLOW_SHIFT;
        if (flow_q > PROD_W'(bbsf_pkg::SAT_LIMIT)) begin
            flow_sat = bbsf_pkg::SAMPLE_W'(bbsf_pkg::SAT_LIMIT);
        end else if (flow_q < -PROD_W'(bbsf_pkg::SAT_LIMIT)) begin
            flow_sat = -bbsf_pkg::SAMPLE_W'(bbsf_pkg::SAT_LIMIT);
        end else begin
            flow_sat = flow_q[bbsf_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_delay <= bbsf_pkg::RST_BASELINE_DELAY;
            r_cfg_avg   <= bbsf_pkg::RST_BASELINE_AVG;
            r_cfg_tdiv  <= bbsf_pkg::RST_THORACIC_DIV;
            r_cfg_adiv  <= bbsf_pkg::RST_ABDOMEN_DIV;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bbsf_pkg::CFG_BASELINE_DELAY: r_cfg_delay <= i_cfg_data;
                bbsf_pkg::CFG_BASELINE_AVG:
                    r_cfg_avg <= i_cfg_data[bbsf_pkg::DIVISOR_W-1:0];
                bbsf_pkg::CFG_THORACIC_DIV:
                    r_cfg_tdiv <= i_cfg_data[bbsf_pkg::DIVISOR_W-1:0];
                bbsf_pkg::CFG_ABDOMEN_DIV:
                    r_cfg_adiv <= i_cfg_data[bbsf_pkg::DIVISOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_bvalid  <= 1'b0;
            r_base_t  <= '0;
            r_base_a  <= '0;
            r_sum_t   <= '0;
            r_sum_a   <= '0;
            r_avg     <= '0;
        end else begin
            // In S_FIN the output valid is handled together with the load.
            if (r_o_valid && i_ready && (r_state != S_FIN)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in_thor <= i_thoracic_count;
                        r_in_abd  <= i_abdomen_count;
                        r_in_pres <= i_pressure_q16;
                        r_in_secs <= i_elapsed_seconds;
                        r_in_rr   <= frame.rr_take ? i_rr_interval_ms : '0;
                        r_frame   <= frame;
                        r_state   <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_prod  <= prod;
                    r_state <= S_ST_GO;
                    if (take_avg) begin
                        r_sum_t <= r_sum_t + bbsf_pkg::SUM_W'(r_in_thor);
                        r_sum_a <= r_sum_a + bbsf_pkg::SUM_W'(r_in_abd);
                        r_avg   <= avg_inc[bbsf_pkg::DIVISOR_W-1:0];
                        if (avg_inc >= {1'b0, r_cfg_avg}) begin
                            r_state <= S_BT_GO;
                        end
                    end
                end
                S_BT_GO: r_state <= S_BT_WT;
                S_BT_WT: begin
                    if (div_done) begin
                        r_base_t <= div_quot[bbsf_pkg::COUNT_W-1:0];
                        r_state  <= S_BA_GO;
                    end
                end
                S_BA_GO: r_state <= S_BA_WT;
                S_BA_WT: begin
                    if (div_done) begin
                        r_base_a <= div_quot[bbsf_pkg::COUNT_W-1:0];
                        r_bvalid <= 1'b1;
                        r_state  <= S_ST_GO;
                    end
                end
                S_ST_GO: begin
                    r_neg   <= diff_neg;
                    r_state <= S_ST_WT;
                end
                S_ST_WT: begin
                    if (div_done) begin
                        r_samp_t <= samp;
                        r_state  <= S_SA_GO;
                    end
                end
                S_SA_GO: begin
                    r_neg   <= diff_neg;
                    r_state <= S_SA_WT;
                end
                S_SA_WT: begin
                    if (div_done) begin
                        r_samp_a <= samp;
                        r_state  <= S_FLOW1;
                    end
                end
                S_FLOW1: begin
                    r_flow  <= flow_sat;
                    r_state <= S_FLOW2;
                end
                S_FLOW2: r_state <= S_FIN;
                S_FIN: begin
                    // Load the result once the previous one has been taken.
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_thor   <= r_samp_t;
                        r_o_abd    <= r_samp_a;
                        r_o_flow   <= r_flow;
                        r_o_frame  <= r_frame;
                        r_o_rr     <= r_in_rr;
                        r_o_bready <= r_bvalid;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_o_valid;
    assign o_thoracic_sample  = r_o_thor;
    assign o_abdomen_sample   = r_o_abd;
    assign o_flow_sample      = r_o_flow;
    assign o_slot_index       = r_o_frame.slot_index;
    assign o_rr_take          = r_o_frame.rr_take;
    assign o_rr_slot          = r_o_frame.rr_slot;
    assign o_rr_value         = r_o_rr;
    assign o_record_end       = r_o_frame.record_end;
    assign o_header_flush_due = r_o_frame.header_flush_due;
    assign o_baseline_ready   = r_o_bready;

endmodule

/* hdl/bbsf_div.sv */
module bbsf_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bbsf_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  logic [bbsf_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic [bbsf_pkg::DIVIDEND_W-1:0]   o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [bbsf_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [bbsf_pkg::DIVISOR_W-1:0]    r_rem;
    logic [bbsf_pkg::DIVISOR_W-1:0]    r_dvs;
    logic [bbsf_pkg::DIVIDEND_W-1:0]   r_quo;

    logic [bbsf_pkg::DIVISOR_W:0]      trial;
    logic [bbsf_pkg::DIVISOR_W:0]      diff;
    logic                              fits;
    logic [bbsf_pkg::DIVISOR_W-1:0]    n_rem;

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out of the top of r_quo while quotient bits shift in at the bottom.
    always_comb begin
        trial = {r_rem, r_quo[bbsf_pkg::DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem = fits ? diff[bbsf_pkg::DIVISOR_W-1:0] : trial[bbsf_pkg::DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == bbsf_pkg::DIV_CNT_W'(bbsf_pkg::DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[bbsf_pkg::DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* hdl/bbsf_frame.sv */
module bbsf_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    output bbsf_pkg::t_frame    o_frame
);

    logic [bbsf_pkg::SLOT_W-1:0]    r_slot;
    logic [bbsf_pkg::RR_SUB_W-1:0]  r_sub;
    logic [bbsf_pkg::RR_SLOT_W-1:0] r_rr_cnt;
    logic [bbsf_pkg::RECORDS_W-1:0] r_records;
    logic [bbsf_pkg::FLUSH_W-1:0]   r_flush_cnt;

    logic [bbsf_pkg::SLOT_W:0]      slot_inc;
    logic [bbsf_pkg::RECORDS_W-1:0] rec_inc;
    logic                           take;
    logic                           rend;
    logic                           rec_wrap;
    logic                           flush_hit;

    always_comb begin
        slot_inc  = {1'b0, r_slot} + 1'b1;
        rec_inc   = r_records + 1'b1;
        take      = (r_sub == bbsf_pkg::RR_SUB_W'(bbsf_pkg::RR_EVERY - 1)) &&
                    (r_rr_cnt < bbsf_pkg::RR_SLOT_W'(bbsf_pkg::RR_PER_RECORD));
        rend      = (slot_inc >= (bbsf_pkg::SLOT_W + 1)'(bbsf_pkg::TICKS_PER_RECORD));
        // A record count that wraps to zero is a multiple of ten as well, and
        // the residue counter restarts from there.
        rec_wrap  = (rec_inc == '0);
        flush_hit = rec_wrap ||
                    (r_flush_cnt == bbsf_pkg::FLUSH_W'(bbsf_pkg::FLUSH_EVERY - 1));

        o_frame.slot_index       = r_slot;
        o_frame.rr_take          = take;
        o_frame.rr_slot          = take ? r_rr_cnt : '0;
        o_frame.record_end       = rend;
        o_frame.header_flush_due = rend && flush_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_sub       <= '0;
            r_rr_cnt    <= '0;
            r_records   <= '0;
            r_flush_cnt <= '0;
        end else if (i_step) begin
            if (rend) begin
                r_slot      <= '0;
                r_sub       <= '0;
                r_rr_cnt    <= '0;
                r_records   <= rec_inc;
                r_flush_cnt <= flush_hit ? '0 : r_flush_cnt + 1'b1;
            end else begin
                r_slot <= slot_inc[bbsf_pkg::SLOT_W-1:0];
                r_sub  <= (r_sub == bbsf_pkg::RR_SUB_W'(bbsf_pkg::RR_EVERY - 1)) ?
                          '0 : r_sub + 1'b1;
                if (take) begin
                    r_rr_cnt <= r_rr_cnt + 1'b1;
                end
            end
        end
    end

endmodule
